// ===== rtl/efr_pkg.sv =====
// Shared types and constants for the escaped table frame receiver.
package efr_pkg;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [7:0] ESC_FLIP      = 8'h20;
    localparam logic [7:0] SYNC_RESET    = 8'd126;
    localparam logic [7:0] ESCAPE_RESET  = 8'd125;

    typedef enum logic [0:0] {
        REG_SYNC   = 1'b0,
        REG_ESCAPE = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        KIND_ROUTE   = 2'd0,
        KIND_POWER   = 2'd1,
        KIND_LEN_ERR = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_LOAD = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

endpackage

// ===== rtl/escaped_table_frame_receiver.sv =====
// Top level of the escaped table frame receiver with its register port.
// A byte that causes no result is taken while o_stall stays low.
// A failed close shows its single error result in the cycle after acceptance.
// A good close emits 2*TABLE_ENTRIES results, each through the READ, LOAD and EMIT states and the buffer read port.
// Throughput: one byte per cycle while o_stall is low; no input is taken during readout or error output.
// Reset is synchronous and active low; the buffer has no clearing pass.
module escaped_table_frame_receiver
    import efr_pkg::*;
#(
    parameter int TABLE_ENTRIES = 8,
    parameter int BUFFER_BYTES  = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [DATA_W-1:0] i_pwdata,
    output logic [DATA_W-1:0] o_prdata,
    output logic              o_pready,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_byte_in,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_kind,
    output logic [2:0]        o_entry_index,
    output logic [7:0]        o_entry_value,
    output logic              o_last
);

    logic [7:0] r_sync_value;
    logic [7:0] r_escape_value;
    logic       wr_en;
    t_reg_idx   reg_idx;

    assign o_pready = 1'b1;
    assign wr_en    = i_psel && i_penable && i_pwrite && o_pready;
    assign reg_idx  = t_reg_idx'(i_paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_value   <= SYNC_RESET;
            r_escape_value <= ESCAPE_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_SYNC:   r_sync_value   <= i_pwdata[7:0];
                REG_ESCAPE: r_escape_value <= i_pwdata[7:0];
                default:    r_sync_value   <= r_sync_value;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SYNC:   o_prdata = {{(DATA_W - 8){1'b0}}, r_sync_value};
            REG_ESCAPE: o_prdata = {{(DATA_W - 8){1'b0}}, r_escape_value};
            default:    o_prdata = '0;
        endcase
    end

    efr_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .BUFFER_BYTES  (BUFFER_BYTES)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sync_value   (r_sync_value),
        .i_escape_value (r_escape_value),
        .i_valid        (i_valid),
        .i_byte_in      (i_byte_in),
        .o_stall        (o_stall),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kind         (o_kind),
        .o_entry_index  (o_entry_index),
        .o_entry_value  (o_entry_value),
        .o_last         (o_last)
    );

endmodule

// ===== rtl/efr_buf.sv =====
// Payload buffer memory with one write port and one registered read port.
module efr_buf #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/efr_ctrl.sv =====
// Frame parser and readout sequencer with the result register.
module efr_ctrl
    import efr_pkg::*;
#(
    parameter int TABLE_ENTRIES = 8,
    parameter int BUFFER_BYTES  = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_sync_value,
    input  logic [7:0] i_escape_value,
    input  logic       i_valid,
    input  logic [7:0] i_byte_in,
    output logic       o_stall,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_kind,
    output logic [2:0] o_entry_index,
    output logic [7:0] o_entry_value,
    output logic       o_last
);

    localparam int TOTAL = 2 * TABLE_ENTRIES;
    localparam int AW    = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
    localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
    localparam int RW    = $clog2(TOTAL);
    localparam int CMP_W = 8;

    t_state            r_state, n_state;
    logic              r_in_frame, n_in_frame;
    logic              r_esc, n_esc;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [RW-1:0]     r_rd_idx, n_rd_idx;
    t_kind             r_kind, n_kind;
    logic [2:0]        r_index, n_index;
    logic [7:0]        r_value, n_value;
    logic              r_last, n_last;

    logic              store;
    logic [7:0]        wdata;
    logic [CNT_W-1:0]  count_inc;
    logic [7:0]        rdata;
    logic              half;
    logic [RW-1:0]     rd_rel;

    efr_buf #(
        .DEPTH (BUFFER_BYTES),
        .AW    (AW)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (store),
        .i_waddr (AW'(r_count)),
        .i_wdata (wdata),
        .i_raddr (AW'(r_rd_idx)),
        .o_rdata (rdata)
    );

    assign count_inc = r_count + 1'b1;
    assign half      = (int'(r_rd_idx) >= TABLE_ENTRIES);
    assign rd_rel    = half ? (r_rd_idx - RW'(TABLE_ENTRIES)) : r_rd_idx;

    always_comb begin
        n_state    = r_state;
        n_in_frame = r_in_frame;
        n_esc      = r_esc;
        n_count    = r_count;
        n_rd_idx   = r_rd_idx;
        n_kind     = r_kind;
        n_index    = r_index;
        n_value    = r_value;
        n_last     = r_last;
        store      = 1'b0;
        wdata      = i_byte_in;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (r_in_frame) begin
                        if (r_esc) begin
                            n_esc = 1'b0;
                            store = 1'b1;
                            wdata = i_byte_in ^ ESC_FLIP;
                        end else if (i_byte_in == i_escape_value) begin
                            n_esc = 1'b1;
                        end else if (i_byte_in == i_sync_value) begin
                            n_in_frame = 1'b0;
                            n_count    = '0;
                            if (CMP_W'(r_count) == CMP_W'(TOTAL)) begin
                                n_rd_idx = '0;
                                n_state  = ST_READ;
                            end else begin
                                n_kind  = KIND_LEN_ERR;
                                n_index = '0;
                                n_value = '0;
                                n_last  = 1'b1;
                                n_state = ST_EMIT;
                            end
                        end else begin
                            store = 1'b1;
                        end
                    end else if (i_byte_in == i_sync_value) begin
                        n_in_frame = 1'b1;
                    end else begin
                        n_count = '0;
                    end
                    if (store) begin
                        if (count_inc == CNT_W'(BUFFER_BYTES)) begin
                            n_count    = '0;
                            n_in_frame = 1'b0;
                        end else begin
                            n_count = count_inc;
                        end
                    end
                end
            end
            ST_READ: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                n_kind  = half ? KIND_POWER : KIND_ROUTE;
                n_index = 3'(rd_rel);
                n_value = rdata;
                n_last  = (r_rd_idx == RW'(TOTAL - 1));
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (!i_stall) begin
                    if (r_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_rd_idx = r_rd_idx + 1'b1;
                        n_state  = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_in_frame <= 1'b0;
            r_esc      <= 1'b0;
            r_count    <= '0;
            r_rd_idx   <= '0;
        end else begin
            r_state    <= n_state;
            r_in_frame <= n_in_frame;
            r_esc      <= n_esc;
            r_count    <= n_count;
            r_rd_idx   <= n_rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_index <= n_index;
        r_value <= n_value;
        r_last  <= n_last;
    end

    assign o_stall       = (r_state != ST_IDLE);
    assign o_valid       = (r_state == ST_EMIT);
    assign o_kind        = r_kind;
    assign o_entry_index = r_index;
    assign o_entry_value = r_value;
    assign o_last        = r_last;

endmodule
